[hdl/lfst_pkg.sv]
// Shared types and constants for the lowest-free slot table.
// Used by lfst_ctrl, lfst_dp and the top level; depends on nothing.
package lfst_pkg;

  localparam int SLOTS_DEF        = 64;
  localparam int HANDLE_WIDTH_DEF = 32;

  localparam int REQ_W      = 2;
  localparam int IDX_W      = 8;
  localparam int HANDLE_IO_W = 32;
  localparam int SLOT_OUT_W = 6;
  localparam int STATUS_W   = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the request word, start the table read
    logic commit;   // update the table and load the result register
  } cmd_t;

endpackage

[hdl/lfst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module lfst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lfst_ctrl.sv]
// Controller for the slot table: request/result handshakes and sequencing.
// Depends on lfst_pkg for the command struct.
module lfst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lfst_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/lfst_dp.sv]
// Datapath for the slot table: request registers, occupancy bits, lowest-free
// encoder, handle RAM and result registers. Depends on lfst_pkg and lfst_ram.
module lfst_dp #(
  parameter int SLOTS        = lfst_pkg::SLOTS_DEF,
  parameter int HANDLE_WIDTH = lfst_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lfst_pkg::cmd_t                      cmd,
  input  logic [lfst_pkg::REQ_W-1:0]          in_req_type,
  input  logic [lfst_pkg::IDX_W-1:0]          in_slot_index,
  input  logic [lfst_pkg::HANDLE_IO_W-1:0]    in_handle_in,
  output logic [lfst_pkg::SLOT_OUT_W-1:0]     out_slot_out,
  output logic [lfst_pkg::HANDLE_IO_W-1:0]    out_handle_out,
  output logic [lfst_pkg::STATUS_W-1:0]       out_status
);

  localparam int SLOT_IDX_W = $clog2(SLOTS);
  localparam logic [lfst_pkg::IDX_W:0] SLOTS_LIM = (lfst_pkg::IDX_W + 1)'(SLOTS);

  logic [lfst_pkg::REQ_W-1:0]      req_r;
  logic [lfst_pkg::IDX_W-1:0]      idx_r;
  logic [HANDLE_WIDTH-1:0]         hdl_r;
  logic [SLOTS-1:0]                occ_r, occ_nxt;

  logic [lfst_pkg::SLOT_OUT_W-1:0] slot_out_r, slot_out_nxt;
  logic [lfst_pkg::HANDLE_IO_W-1:0] handle_out_r, handle_out_nxt;
  logic [lfst_pkg::STATUS_W-1:0]   status_r, status_nxt;

  logic [SLOTS-1:0]                low_free;
  logic [SLOT_IDX_W-1:0]           free_idx;
  logic                            full;
  logic                            in_range;
  logic [SLOT_IDX_W-1:0]           idx_a;

  logic                            ram_we;
  logic [SLOT_IDX_W-1:0]           ram_waddr;
  logic [HANDLE_WIDTH-1:0]         ram_wdata;
  logic [HANDLE_WIDTH-1:0]         ram_rdata;

  // Request word; the table read starts in the same cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      idx_r <= in_slot_index;
      hdl_r <= HANDLE_WIDTH'(in_handle_in);
    end
  end

  lfst_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (in_slot_index[SLOT_IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Lowest free slot: isolate the lowest clear occupancy bit, then encode.
  // An all-ones map wraps to zero, so no bit survives.
  always_comb begin
    low_free = ~occ_r & (occ_r + SLOTS'(1));
    full     = &occ_r;
    free_idx = '0;
    for (int b = 0; b < SLOT_IDX_W; b++) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (((i >> b) & 1) == 1) begin
          free_idx[b] = free_idx[b] | low_free[i];
        end
      end
    end
  end

  assign in_range = ({1'b0, idx_r} < SLOTS_LIM);
  assign idx_a    = idx_r[SLOT_IDX_W-1:0];

  always_comb begin
    occ_nxt        = occ_r;
    ram_we         = 1'b0;
    ram_waddr      = free_idx;
    ram_wdata      = hdl_r;
    slot_out_nxt   = '0;
    handle_out_nxt = '0;
    status_nxt     = lfst_pkg::ST_DONE;
    unique case (req_r)
      lfst_pkg::REQ_ALLOC: begin
        if (full) begin
          status_nxt = lfst_pkg::ST_FULL;
        end else begin
          ram_we            = cmd.commit;
          occ_nxt[free_idx] = |hdl_r;
          slot_out_nxt      = lfst_pkg::SLOT_OUT_W'(free_idx);
        end
      end
      lfst_pkg::REQ_LOOKUP: begin
        slot_out_nxt = idx_r[lfst_pkg::SLOT_OUT_W-1:0];
        if (!in_range) begin
          status_nxt = lfst_pkg::ST_RANGE;
        end else if (occ_r[idx_a]) begin
          // a clear occupancy bit means the entry reads as zero
          handle_out_nxt = lfst_pkg::HANDLE_IO_W'(ram_rdata);
        end
      end
      lfst_pkg::REQ_FREE: begin
        slot_out_nxt = idx_r[lfst_pkg::SLOT_OUT_W-1:0];
        if (!in_range) begin
          status_nxt = lfst_pkg::ST_RANGE;
        end else begin
          ram_we         = cmd.commit;
          ram_waddr      = idx_a;
          ram_wdata      = '0;
          occ_nxt[idx_a] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.commit) begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_out_r   <= slot_out_nxt;
      handle_out_r <= handle_out_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_slot_out   = slot_out_r;
  assign out_handle_out = handle_out_r;
  assign out_status     = status_r;

endmodule

[hdl/lowest_free_slot_table.sv]
// Lowest-free slot table: top level joining controller and datapath.
// Depends on lfst_pkg, lfst_ctrl, lfst_dp and lfst_ram.
//
// Usage:
//   Request channel (in_valid/in_ready): in_req_type selects allocate,
//   lookup or free; in_slot_index names the slot for lookup and free;
//   in_handle_in is the handle stored by allocate (zero stores nothing).
//   Result channel (out_valid/out_ready): one word per request with
//   out_slot_out, out_handle_out and out_status (done, full, out of range).
// Timing:
//   A request is taken when the block is idle; the handle RAM is read in
//   that cycle. In the execute state, once the result register is free or
//   draining, an allocate picks the lowest free slot, the table is updated
//   as the request needs and the result register is loaded. No new request
//   is taken until then; the registered RAM read comes ahead of the update.
// Reset:
//   Synchronous, active low; clears the occupancy bits so every slot reads
//   free and zero at once. No clearing pass is needed.
// Stall:
//   A result waits in the output register while out_ready is low; the next
//   request is still taken and holds in the execute state until it drains.
module lowest_free_slot_table #(
  parameter int SLOTS        = lfst_pkg::SLOTS_DEF,
  parameter int HANDLE_WIDTH = lfst_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lfst_pkg::REQ_W-1:0]        in_req_type,
  input  logic [lfst_pkg::IDX_W-1:0]        in_slot_index,
  input  logic [lfst_pkg::HANDLE_IO_W-1:0]  in_handle_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lfst_pkg::SLOT_OUT_W-1:0]   out_slot_out,
  output logic [lfst_pkg::HANDLE_IO_W-1:0]  out_handle_out,
  output logic [lfst_pkg::STATUS_W-1:0]     out_status
);

  lfst_pkg::cmd_t cmd;

  lfst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lfst_dp #(
    .SLOTS        (SLOTS),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_slot_index  (in_slot_index),
    .in_handle_in   (in_handle_in),
    .out_slot_out   (out_slot_out),
    .out_handle_out (out_handle_out),
    .out_status     (out_status)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for lowest_free_slot_table: drives allocate, lookup and free
// words, mirrors the slot table locally to predict each result word and checks it.
// Depends on lfst_pkg and the lowest_free_slot_table RTL.
module tb;

  localparam int REQ_W       = lfst_pkg::REQ_W;
  localparam int IDX_W       = lfst_pkg::IDX_W;
  localparam int HANDLE_IO_W = lfst_pkg::HANDLE_IO_W;
  localparam int SLOT_OUT_W  = lfst_pkg::SLOT_OUT_W;
  localparam int STATUS_W    = lfst_pkg::STATUS_W;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int NSLOTS = lfst_pkg::SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0]  slot;
    logic [HANDLE_IO_W-1:0] handle;
    logic [STATUS_W-1:0]    status;
  } slot_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [REQ_W-1:0]       in_req_type = '0;
  logic [IDX_W-1:0]       in_slot_index = '0;
  logic [HANDLE_IO_W-1:0] in_handle_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SLOT_OUT_W-1:0]  out_slot_out;
  logic [HANDLE_IO_W-1:0] out_handle_out;
  logic [STATUS_W-1:0]    out_status;

  int send_idle_pct = 25;
  int recv_stall_pct = 50;
  int error_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int full_seen = 0;
  int range_seen = 0;
  int zero_alloc_seen = 0;
  int cycle_count = 0;

  slot_result_t           expected_words[$];
  logic [HANDLE_IO_W-1:0] mirror_handle [NSLOTS];
  logic                   mirror_busy [NSLOTS];

  lowest_free_slot_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_slot_index  (in_slot_index),
    .in_handle_in   (in_handle_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot_out   (out_slot_out),
    .out_handle_out (out_handle_out),
    .out_status     (out_status)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      mirror_handle[i] = '0;
      mirror_busy[i] = 1'b0;
    end
  end

  // Apply one request to the mirrored table and return the word it should produce.
  function automatic slot_result_t predict_slot_word(input logic [REQ_W-1:0] rt,
      input logic [IDX_W-1:0] idx, input logic [HANDLE_IO_W-1:0] h);
    slot_result_t r;
    int lowest;
    r = '0;
    lowest = -1;
    case (rt)
      lfst_pkg::REQ_ALLOC: begin
        for (int i = NSLOTS - 1; i >= 0; i--) if (!mirror_busy[i]) lowest = i;
        if (lowest < 0) begin
          r.status = lfst_pkg::ST_FULL;
        end else begin
          // a zero handle reports the slot but leaves it free
          mirror_handle[lowest] = h;
          mirror_busy[lowest] = (h != '0);
          r.slot = lowest[SLOT_OUT_W-1:0];
        end
      end
      lfst_pkg::REQ_LOOKUP: begin
        r.slot = idx[SLOT_OUT_W-1:0];
        if (idx < NSLOTS) r.handle = mirror_handle[idx];
        else r.status = lfst_pkg::ST_RANGE;
      end
      lfst_pkg::REQ_FREE: begin
        r.slot = idx[SLOT_OUT_W-1:0];
        if (idx < NSLOTS) begin
          mirror_handle[idx] = '0;
          mirror_busy[idx] = 1'b0;
        end else begin
          r.status = lfst_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [HANDLE_IO_W-1:0] pick_handle();
    case ($urandom_range(15))
      0: return '0;
      1: return HANDLE_IO_W'($urandom_range(255));
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Prefer an occupied slot when asked; otherwise mostly in range, sometimes not.
  function automatic logic [IDX_W-1:0] pick_index(input bit want_busy);
    int busy_list[$];
    for (int i = 0; i < NSLOTS; i++) if (mirror_busy[i]) busy_list.push_back(i);
    if (want_busy && busy_list.size() > 0)
      return IDX_W'(busy_list[$urandom_range(busy_list.size() - 1)]);
    if ($urandom_range(7) == 0) return IDX_W'($urandom_range(255));
    return IDX_W'($urandom_range(NSLOTS - 1));
  endfunction

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lowest_free_slot_table verification failed");
      $finish;
    end
  end

  // Check the result word first, then record any request word taken on this edge.
  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no request outstanding");
          error_count++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (out_slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, out_slot_out);
            error_count++;
          end
          if (out_handle_out !== want.handle) begin
            $error("handle_out: expected %08h, got %08h", want.handle, out_handle_out);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
          if (want.status == lfst_pkg::ST_FULL) full_seen++;
          if (want.status == lfst_pkg::ST_RANGE) range_seen++;
        end
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(predict_slot_word(in_req_type, in_slot_index, in_handle_in));
        words_sent++;
        if (in_req_type == lfst_pkg::REQ_ALLOC && in_handle_in == '0) zero_alloc_seen++;
      end
    end
  end

  // Called and returns at a falling edge; hold valid high across back-to-back words.
  task automatic send_request(input logic [REQ_W-1:0] rt, input logic [IDX_W-1:0] idx,
      input logic [HANDLE_IO_W-1:0] h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rt;
    in_slot_index <= idx;
    in_handle_in  <= h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(lfst_pkg::REQ_LOOKUP, 8'd0, 32'hFFFF_FFFF);
    send_request(lfst_pkg::REQ_LOOKUP, IDX_W'(NSLOTS - 1), '0);
    send_request(lfst_pkg::REQ_LOOKUP, IDX_W'(NSLOTS), '0);
    send_request(lfst_pkg::REQ_LOOKUP, 8'd255, '0);
    send_request(lfst_pkg::REQ_FREE, IDX_W'(NSLOTS), '0);
    send_request(lfst_pkg::REQ_FREE, 8'd255, 32'hFFFF_FFFF);
    send_request(lfst_pkg::REQ_FREE, 8'd5, '0);
    send_request(lfst_pkg::REQ_ALLOC, 8'd0, '0);
    send_request(lfst_pkg::REQ_LOOKUP, 8'd0, '0);
    send_request(lfst_pkg::REQ_ALLOC, 8'd255, 32'hFFFF_FFFF);
    send_request(lfst_pkg::REQ_ALLOC, 8'd0, 32'h0000_0001);
    send_request(lfst_pkg::REQ_ALLOC, 8'd170, 32'hA5A5_A5A5);
    send_request(lfst_pkg::REQ_LOOKUP, 8'd0, '0);
    send_request(lfst_pkg::REQ_LOOKUP, 8'd1, '0);
    send_request(lfst_pkg::REQ_LOOKUP, 8'd2, '0);
    send_request(lfst_pkg::REQ_FREE, 8'd1, '0);
    send_request(lfst_pkg::REQ_ALLOC, 8'd85, 32'h5A5A_5A5A);
    send_request(lfst_pkg::REQ_LOOKUP, 8'd1, '0);
    send_request(REQ_UNUSED, 8'd255, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 8'd0, '0);
    send_request(lfst_pkg::REQ_FREE, 8'd0, '0);
    send_request(lfst_pkg::REQ_FREE, 8'd1, '0);
    send_request(lfst_pkg::REQ_FREE, 8'd2, '0);
    send_request(lfst_pkg::REQ_LOOKUP, 8'd2, '0);
  endtask

  // Fill every slot, push past full, punch holes, refill, then drain the table.
  task automatic test_table_full();
    repeat (NSLOTS + 3) send_request(lfst_pkg::REQ_ALLOC, IDX_W'($urandom), $urandom | 32'h1);
    send_request(lfst_pkg::REQ_ALLOC, 8'd0, '0);
    send_request(lfst_pkg::REQ_LOOKUP, IDX_W'(NSLOTS - 1), '0);
    repeat (4) send_request(lfst_pkg::REQ_FREE, pick_index(1'b1), $urandom);
    repeat (5) send_request(lfst_pkg::REQ_ALLOC, IDX_W'($urandom), pick_handle());
    for (int i = 0; i < NSLOTS; i++) begin
      if ($urandom_range(1)) send_request(lfst_pkg::REQ_LOOKUP, IDX_W'(i), $urandom);
      send_request(lfst_pkg::REQ_FREE, IDX_W'(i), $urandom);
    end
  endtask

  // Bursts of allocates, bursts of lookups and frees on live slots, and raw noise.
  task automatic test_churn(input int n_items, input int sender_idle, input int receiver_stall);
    int sent;
    int burst;
    int mode;
    sent = 0;
    send_idle_pct = sender_idle;
    recv_stall_pct = receiver_stall;
    while (sent < n_items) begin
      mode = $urandom_range(99);
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if (mode < 40) begin
          send_request(lfst_pkg::REQ_ALLOC, IDX_W'($urandom), pick_handle());
        end else if (mode < 80) begin
          if ($urandom_range(1))
            send_request(lfst_pkg::REQ_LOOKUP, pick_index(1'($urandom_range(1))), $urandom);
          else
            send_request(lfst_pkg::REQ_FREE, pick_index($urandom_range(3) != 0), $urandom);
        end else begin
          send_request(REQ_W'($urandom), IDX_W'($urandom), pick_handle());
        end
      end
      sent += burst;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_churn(495, 25, 50);
    test_churn(495, 50, 25);
    test_churn(495, 0, 0);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d request words and %0d result words checked.",
             words_sent, words_checked);
    $display("Table full seen %0d times, out of range %0d, zero-handle allocates %0d.",
             full_seen, range_seen, zero_alloc_seen);
    if (error_count == 0) begin
      $display("lowest_free_slot_table verification clean");
    end else begin
      $display("lowest_free_slot_table verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lfst_pkg.sv
hdl/lfst_ram.sv
hdl/lfst_ctrl.sv
hdl/lfst_dp.sv
hdl/lowest_free_slot_table.sv
dv/tb.sv
